// File: rtl/pproj_pkg.sv
package pproj_pkg;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [1:0] CFG_WATER_KIND   = 2'd1;
    localparam logic [1:0] CFG_HALF_WIDTH   = 2'd2;

    localparam logic [1:0] WK_RIVER = 2'd0;
    localparam logic [1:0] WK_POND  = 2'd1;
    localparam logic [1:0] WK_LAKE  = 2'd2;
    localparam logic [1:0] WK_SEA   = 2'd3;

    localparam int SQ_W   = 62;
    localparam int ROOT_W = 31;

    localparam int DIV_NUM_W  = 48;
    localparam int DIV_DEN_W  = 50;
    localparam int DIV_STEP_W = 6;
    localparam logic [DIV_STEP_W-1:0] DIV_STEPS_T    = 6'd16;
    localparam logic [DIV_STEP_W-1:0] DIV_STEPS_FULL = 6'd48;

    localparam logic [16:0] T_ONE       = 17'd65536;
    localparam logic [47:0] DIR_MAX     = 48'd16384;
    localparam logic [47:0] ALONG_MAX   = 48'd65536;
    localparam logic [47:0] SPEED_MIN   = 48'd819;
    localparam logic [47:0] SPEED_MAX   = 48'd26214;
    localparam logic [26:0] SPEED_SCALE = 27'd196608;
    localparam logic [23:0] DIST_MAX    = 24'hFFFFFF;

    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] radicand;
    } t_sqrt_req;

    typedef struct packed {
        logic                  start;
        logic [DIV_DEN_W-1:0]  rem_init;
        logic [DIV_NUM_W-1:0]  num;
        logic [DIV_DEN_W-1:0]  den;
        logic [DIV_STEP_W-1:0] steps;
    } t_div_req;

endpackage

// File: rtl/pproj_sqrt.sv
module pproj_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pproj_pkg::t_sqrt_req          i_req,
    output logic                          o_busy,
    output logic [pproj_pkg::ROOT_W-1:0]  o_root,
    output logic [pproj_pkg::ROOT_W:0]    o_root_rnd
);

    logic [pproj_pkg::SQ_W-1:0] r_n;
    logic [pproj_pkg::SQ_W-1:0] r_r;
    logic [pproj_pkg::SQ_W-1:0] r_bit;
    logic                       r_busy;
    logic [pproj_pkg::SQ_W-1:0] trial;
    logic                       fits;

    assign trial = r_r + r_bit;
    assign fits  = r_n >= trial;

    // Bit-by-bit square root of the full radicand; a start restarts it even while busy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_n    <= i_req.radicand;
            r_r    <= '0;
            r_bit  <= pproj_pkg::SQ_W'(1) << (pproj_pkg::SQ_W - 2);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (fits) begin
                r_n <= r_n - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
            if (r_bit[0]) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_root     = r_r[pproj_pkg::ROOT_W-1:0];
    assign o_root_rnd = {1'b0, o_root}
                        + (pproj_pkg::ROOT_W+1)'(r_n > pproj_pkg::SQ_W'(o_root));

endmodule

// File: rtl/pproj_div.sv
module pproj_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pproj_pkg::t_div_req              i_req,
    output logic                             o_busy,
    output logic [pproj_pkg::DIV_NUM_W-1:0]  o_quot
);

    localparam int NW = pproj_pkg::DIV_NUM_W;
    localparam int DW = pproj_pkg::DIV_DEN_W;

    logic [DW-1:0]                    r_rem;
    logic [NW-1:0]                    r_num;
    logic [NW-1:0]                    r_q;
    logic [DW-1:0]                    r_den;
    logic [pproj_pkg::DIV_STEP_W-1:0] r_cnt;
    logic                             r_busy;
    logic [DW:0]                      rem_sh;
    logic                             ge;

    assign rem_sh = {r_rem, r_num[NW-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    // Restoring division, one quotient bit per cycle. A nonzero starting
    // remainder continues a fraction below one for as many steps as asked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_rem  <= i_req.rem_init;
            r_num  <= i_req.num;
            r_den  <= i_req.den;
            r_q    <= '0;
            r_cnt  <= i_req.steps;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_rem <= ge ? DW'(rem_sh - {1'b0, r_den}) : DW'(rem_sh);
            r_num <= r_num << 1;
            r_q   <= {r_q[NW-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == pproj_pkg::DIV_STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

// File: rtl/polyline_point_projection_top.sv
// Polyline point projection.
// Input beats (s_axis) carry either a vertex write (tuser low) or a query
// point (tuser high). A write stores one vertex and makes
// no output beat. A query produces one output beat (m_axis) with the nearest
// segment, the parameter along it, the distance, arc and total lengths, the
// interpolated height, flow direction, along fraction, inside flag and speed.
// A query walks the segments in order through one shared multiplier, a
// restoring divider (16 steps for t, 48 for the later quotients) and a
// 31-step square root unit, then works out height, the flow direction
// (river only), along fraction, the speed (river only), the final
// distance root and the output load. These iterative units set its duration.
// s_axis_tready is low for the whole query. The finished beat sits in an
// output register; the next input beat is taken while it waits, but a later
// query cannot finish until it leaves.
// Configuration writes go through i_cfg_we; the user must make them only while the block is idle (not enforced here).
// Reset clears the configuration registers, output valid and control state;
// vertex memory is not cleared and must be written before it is used.
module polyline_point_projection_top #(
    parameter int MAX_VERTICES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [23:0]   i_cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // vertex_index[5:0], pos_x[29:6], pos_z[53:30], vertex_height[77:54], zero pad
    input  logic [79:0]   s_axis_tdata,
    // op[0]
    input  logic          s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // distance[23:0], segment[29:24], t_frac[46:30], arc_to_foot[78:47],
    // total_length[110:79], surface_height[134:111], flow_dir_x[150:135],
    // flow_dir_z[166:151], along_frac[183:167], inside_res[184], flow_speed[199:185]
    output logic [199:0]  m_axis_tdata
);

    localparam int AW = $clog2(MAX_VERTICES);

    typedef enum logic [5:0] {
        S_IDLE, S_LD0, S_SEG, S_M1, S_M2, S_M3, S_M4, S_M5, S_TDEC, S_TDIV,
        S_LSQ, S_LSQW, S_E1, S_E2, S_E3, S_E4, S_E5, S_UPD, S_PH, S_PH2,
        S_DSQ, S_DSQW, S_DXD, S_DXW, S_DZD, S_DZW, S_AL, S_ALW, S_SP1, S_SP2,
        S_SPW, S_QSQ, S_QSQW, S_OUT
    } t_state;

    function automatic logic signed [37:0] rdiv16(input logic signed [53:0] v);
        logic signed [53:0] tmp;
        tmp = v + 54'sd32768;
        return 38'(tmp >>> 16);
    endfunction

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFFFFFF : s[31:0];
    endfunction

    t_state r_state;

    logic [6:0]  r_vcount;
    logic [1:0]  r_wkind;
    logic [23:0] r_hw;

    logic [71:0] mem [MAX_VERTICES];
    logic [71:0] r_rd;
    logic [AW-1:0] rd_addr;

    logic        in_acc;
    logic [5:0]  in_idx;
    logic        wr_en;
    logic [6:0]  n_lim;
    logic        river;
    logic        sea;

    logic signed [23:0] rd_x, rd_z, rd_h;
    logic signed [23:0] r_px, r_pz;
    logic signed [23:0] r_ax, r_az, r_ah, r_bx, r_bz, r_bh, r_hfirst;
    logic signed [24:0] r_dx, r_dz, r_abx, r_abz;
    logic signed [53:0] r_prod;
    logic signed [26:0] mul_a, mul_b;
    logic [49:0]        r_len2;
    logic signed [51:0] r_dot;
    logic [16:0]        r_t;
    logic [24:0]        r_len;
    logic signed [26:0] r_ex, r_ez;
    logic [51:0]        r_e2;
    logic [6:0]         r_n;
    logic [AW-1:0]      r_i;
    logic [31:0]        r_arc;

    logic [51:0]        r_best_e2;
    logic [AW-1:0]      r_best_seg;
    logic [16:0]        r_best_t;
    logic [31:0]        r_best_arc;
    logic signed [24:0] r_best_abx, r_best_abz;
    logic [49:0]        r_best_len2;
    logic signed [23:0] r_best_h0, r_best_h1;

    logic signed [23:0] r_surf;
    logic signed [15:0] r_dirx, r_dirz;
    logic [16:0]        r_along;
    logic [14:0]        r_speed;
    logic [23:0]        r_dist;
    logic               r_inside;
    logic [pproj_pkg::ROOT_W-1:0] r_ls;

    logic               r_out_valid;
    logic [199:0]       r_out_data;

    logic signed [24:0] hdiff, desc;
    logic [24:0]        desc_pos;
    logic [24:0]        abs_abx, abs_abz;
    logic [31:0]        seg32;
    logic [31:0]        lt_rnd;
    logic               more_seg;
    logic               t_divide;

    pproj_pkg::t_sqrt_req          sq_req;
    logic                          sq_busy;
    logic [pproj_pkg::ROOT_W-1:0]  sq_root;
    logic [pproj_pkg::ROOT_W:0]    sq_rnd;
    pproj_pkg::t_div_req           dv_req;
    logic                          dv_busy;
    logic [pproj_pkg::DIV_NUM_W-1:0] dv_q;

    pproj_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (sq_req),
        .o_busy     (sq_busy),
        .o_root     (sq_root),
        .o_root_rnd (sq_rnd)
    );

    pproj_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dv_req),
        .o_busy  (dv_busy),
        .o_quot  (dv_q)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_idx        = s_axis_tdata[5:0];
    assign wr_en         = in_acc && (s_axis_tuser == pproj_pkg::OP_WRITE)
                           && (32'(in_idx) < MAX_VERTICES);
    assign n_lim         = (32'(r_vcount) > MAX_VERTICES) ? 7'(MAX_VERTICES) : r_vcount;
    assign river         = (r_wkind == pproj_pkg::WK_RIVER);
    assign sea           = (r_wkind == pproj_pkg::WK_SEA);

    assign rd_x = r_rd[23:0];
    assign rd_z = r_rd[47:24];
    assign rd_h = r_rd[71:48];

    assign hdiff    = 25'(r_best_h1) - 25'(r_best_h0);
    assign desc     = 25'(r_hfirst) - 25'(r_bh);
    assign desc_pos = desc[24] ? '0 : desc;
    assign abs_abx  = r_best_abx[24] ? 25'(-r_best_abx) : r_best_abx;
    assign abs_abz  = r_best_abz[24] ? 25'(-r_best_abz) : r_best_abz;
    assign seg32    = 32'(r_best_seg);
    assign lt_rnd   = 32'((r_prod[47:0] + 48'd32768) >> 16);
    assign more_seg = (32'(r_i) + 32'd2) < 32'(r_n);
    assign t_divide = (r_len2 != '0) && (r_dot > 0) && (52'(r_dot) < 52'(r_len2));

    always_comb begin
        case (r_state)
            S_IDLE:  rd_addr = '0;
            S_LD0:   rd_addr = AW'(1);
            S_UPD:   rd_addr = AW'(32'(r_i) + 32'd2);
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[AW'(32'(in_idx))] <= s_axis_tdata[77:6];
        end
        r_rd <= mem[rd_addr];
    end

    // Shared multiplier operands.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_M1: begin mul_a = 27'(r_abx); mul_b = 27'(r_abx); end
            S_M2: begin mul_a = 27'(r_abz); mul_b = 27'(r_abz); end
            S_M3: begin mul_a = 27'(r_dx);  mul_b = 27'(r_abx); end
            S_M4: begin mul_a = 27'(r_dz);  mul_b = 27'(r_abz); end
            S_E1: begin mul_a = 27'(r_abx); mul_b = $signed({10'b0, r_t}); end
            S_E2: begin mul_a = 27'(r_abz); mul_b = $signed({10'b0, r_t}); end
            S_E3: begin mul_a = r_ex;       mul_b = r_ex; end
            S_E4: begin mul_a = r_ez;       mul_b = r_ez; end
            S_E5: begin mul_a = $signed({2'b0, r_len}); mul_b = $signed({10'b0, r_t}); end
            S_PH: begin mul_a = 27'(hdiff); mul_b = $signed({10'b0, r_best_t}); end
            S_SP1: begin
                mul_a = $signed({2'b0, desc_pos});
                mul_b = $signed(pproj_pkg::SPEED_SCALE);
            end
            default: begin end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_comb begin
        sq_req = '0;
        case (r_state)
            S_LSQ: begin
                sq_req.start    = 1'b1;
                sq_req.radicand = pproj_pkg::SQ_W'(r_len2);
            end
            S_DSQ: begin
                sq_req.start    = 1'b1;
                sq_req.radicand = {r_best_len2, 12'b0};
            end
            S_QSQ: begin
                sq_req.start    = 1'b1;
                sq_req.radicand = pproj_pkg::SQ_W'(r_best_e2);
            end
            default: begin end
        endcase
    end

    always_comb begin
        dv_req = '0;
        case (r_state)
            S_TDEC: begin
                dv_req.start    = t_divide;
                dv_req.rem_init = r_dot[49:0];
                dv_req.den      = r_len2;
                dv_req.steps    = pproj_pkg::DIV_STEPS_T;
            end
            S_DXD: begin
                dv_req.start = 1'b1;
                dv_req.num   = (48'(abs_abx) << 20) + 48'(r_ls >> 1);
                dv_req.den   = 50'(r_ls);
                dv_req.steps = pproj_pkg::DIV_STEPS_FULL;
            end
            S_DZD: begin
                dv_req.start = 1'b1;
                dv_req.num   = (48'(abs_abz) << 20) + 48'(r_ls >> 1);
                dv_req.den   = 50'(r_ls);
                dv_req.steps = pproj_pkg::DIV_STEPS_FULL;
            end
            S_AL: begin
                dv_req.start = (r_arc != '0);
                dv_req.num   = {r_best_arc, 16'b0};
                dv_req.den   = 50'(r_arc);
                dv_req.steps = pproj_pkg::DIV_STEPS_FULL;
            end
            S_SP2: begin
                dv_req.start = 1'b1;
                dv_req.num   = r_prod[47:0];
                dv_req.den   = 50'(r_arc);
                dv_req.steps = pproj_pkg::DIV_STEPS_FULL;
            end
            default: begin end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vcount    <= '0;
            r_wkind     <= '0;
            r_hw        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pproj_pkg::CFG_VERTEX_COUNT: r_vcount <= i_cfg_data[6:0];
                    pproj_pkg::CFG_WATER_KIND:   r_wkind  <= i_cfg_data[1:0];
                    pproj_pkg::CFG_HALF_WIDTH:   r_hw     <= i_cfg_data;
                    default: begin end
                endcase
            end

            if (r_state == S_OUT && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc && s_axis_tuser == pproj_pkg::OP_QUERY) begin
                        r_px       <= s_axis_tdata[29:6];
                        r_pz       <= s_axis_tdata[53:30];
                        r_n        <= n_lim;
                        r_i        <= '0;
                        r_arc      <= '0;
                        r_best_e2  <= '0;
                        r_best_seg <= '0;
                        r_best_t   <= '0;
                        r_best_arc <= '0;
                        r_surf     <= '0;
                        r_dirx     <= '0;
                        r_dirz     <= '0;
                        r_along    <= '0;
                        r_speed    <= '0;
                        r_dist     <= pproj_pkg::DIST_MAX;
                        r_inside   <= sea;
                        r_state    <= (n_lim == '0) ? S_OUT : S_LD0;
                    end
                end
                S_LD0: begin
                    r_ax     <= rd_x;
                    r_az     <= rd_z;
                    r_ah     <= rd_h;
                    r_hfirst <= rd_h;
                    r_surf   <= rd_h;
                    r_ex     <= 27'(r_px) - 27'(rd_x);
                    r_ez     <= 27'(r_pz) - 27'(rd_z);
                    r_t      <= '0;
                    r_len    <= '0;
                    r_state  <= (r_n == 7'd1) ? S_E3 : S_SEG;
                end
                S_SEG: begin
                    r_bx    <= rd_x;
                    r_bz    <= rd_z;
                    r_bh    <= rd_h;
                    r_abx   <= 25'(rd_x) - 25'(r_ax);
                    r_abz   <= 25'(rd_z) - 25'(r_az);
                    r_dx    <= 25'(r_px) - 25'(r_ax);
                    r_dz    <= 25'(r_pz) - 25'(r_az);
                    r_state <= S_M1;
                end
                S_M1: r_state <= S_M2;
                S_M2: begin
                    r_len2  <= 50'(r_prod[48:0]);
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_len2  <= r_len2 + 50'(r_prod[48:0]);
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_dot   <= $signed(r_prod[51:0]);
                    r_state <= S_M5;
                end
                S_M5: begin
                    r_dot   <= r_dot + $signed(r_prod[51:0]);
                    r_state <= S_TDEC;
                end
                S_TDEC: begin
                    if (t_divide) begin
                        r_state <= S_TDIV;
                    end else begin
                        // Past the far end clamps to one; behind the head,
                        // or a zero-length segment, gives zero.
                        r_t     <= (r_len2 != '0 && r_dot > 0) ? pproj_pkg::T_ONE : '0;
                        r_state <= S_LSQ;
                    end
                end
                S_TDIV: begin
                    if (!dv_busy) begin
                        r_t     <= dv_q[16:0];
                        r_state <= S_LSQ;
                    end
                end
                S_LSQ: r_state <= S_LSQW;
                S_LSQW: begin
                    if (!sq_busy) begin
                        r_len   <= sq_rnd[24:0];
                        r_state <= S_E1;
                    end
                end
                S_E1: r_state <= S_E2;
                S_E2: begin
                    r_ex    <= 27'(r_dx) - 27'(rdiv16(r_prod));
                    r_state <= S_E3;
                end
                S_E3: begin
                    if (r_n != 7'd1) begin
                        r_ez <= 27'(r_dz) - 27'(rdiv16(r_prod));
                    end
                    r_state <= S_E4;
                end
                S_E4: begin
                    r_e2    <= r_prod[51:0];
                    r_state <= S_E5;
                end
                S_E5: begin
                    r_e2    <= r_e2 + r_prod[51:0];
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (r_n == 7'd1) begin
                        r_best_e2 <= r_e2;
                        r_state   <= S_QSQ;
                    end else begin
                        if (r_i == '0 || r_e2 < r_best_e2) begin
                            r_best_e2   <= r_e2;
                            r_best_seg  <= r_i;
                            r_best_t    <= r_t;
                            r_best_arc  <= sat_add32(r_arc, lt_rnd);
                            r_best_abx  <= r_abx;
                            r_best_abz  <= r_abz;
                            r_best_len2 <= r_len2;
                            r_best_h0   <= r_ah;
                            r_best_h1   <= r_bh;
                        end
                        r_arc <= sat_add32(r_arc, 32'(r_len));
                        if (more_seg) begin
                            r_i     <= r_i + 1'b1;
                            r_ax    <= r_bx;
                            r_az    <= r_bz;
                            r_ah    <= r_bh;
                            r_state <= S_SEG;
                        end else begin
                            r_state <= S_PH;
                        end
                    end
                end
                S_PH: r_state <= S_PH2;
                S_PH2: begin
                    r_surf  <= 24'(38'(r_best_h0) + rdiv16(r_prod));
                    r_state <= (river && r_best_len2 != '0) ? S_DSQ : S_AL;
                end
                S_DSQ: r_state <= S_DSQW;
                S_DSQW: begin
                    if (!sq_busy) begin
                        r_ls    <= sq_root;
                        r_state <= S_DXD;
                    end
                end
                S_DXD: r_state <= S_DXW;
                S_DXW: begin
                    if (!dv_busy) begin
                        if (dv_q > pproj_pkg::DIR_MAX) begin
                            r_dirx <= r_best_abx[24] ? -16'(pproj_pkg::DIR_MAX)
                                                     : 16'(pproj_pkg::DIR_MAX);
                        end else begin
                            r_dirx <= r_best_abx[24] ? -16'(dv_q) : 16'(dv_q);
                        end
                        r_state <= S_DZD;
                    end
                end
                S_DZD: r_state <= S_DZW;
                S_DZW: begin
                    if (!dv_busy) begin
                        if (dv_q > pproj_pkg::DIR_MAX) begin
                            r_dirz <= r_best_abz[24] ? -16'(pproj_pkg::DIR_MAX)
                                                     : 16'(pproj_pkg::DIR_MAX);
                        end else begin
                            r_dirz <= r_best_abz[24] ? -16'(dv_q) : 16'(dv_q);
                        end
                        r_state <= S_AL;
                    end
                end
                S_AL: r_state <= (r_arc != '0) ? S_ALW : S_QSQ;
                S_ALW: begin
                    if (!dv_busy) begin
                        r_along <= (dv_q > pproj_pkg::ALONG_MAX) ? 17'(pproj_pkg::ALONG_MAX)
                                                                 : 17'(dv_q);
                        r_state <= river ? S_SP1 : S_QSQ;
                    end
                end
                S_SP1: r_state <= S_SP2;
                S_SP2: r_state <= S_SPW;
                S_SPW: begin
                    if (!dv_busy) begin
                        if (dv_q < pproj_pkg::SPEED_MIN) begin
                            r_speed <= 15'(pproj_pkg::SPEED_MIN);
                        end else if (dv_q > pproj_pkg::SPEED_MAX) begin
                            r_speed <= 15'(pproj_pkg::SPEED_MAX);
                        end else begin
                            r_speed <= 15'(dv_q);
                        end
                        r_state <= S_QSQ;
                    end
                end
                S_QSQ: r_state <= S_QSQW;
                S_QSQW: begin
                    if (!sq_busy) begin
                        r_dist   <= (sq_rnd > 32'(pproj_pkg::DIST_MAX)) ? pproj_pkg::DIST_MAX
                                                                       : sq_rnd[23:0];
                        r_inside <= (sq_rnd <= 32'(r_hw)) || sea;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_data <= {r_speed, r_inside, r_along, r_dirz, r_dirx, r_surf,
                                       r_arc, r_best_arc, r_best_t, seg32[5:0], r_dist};
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// File: test/polyline_point_projection_checker.sv
module polyline_point_projection_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [23:0]   i_cfg_data,
    input  logic          i_s_tvalid,
    input  logic          i_s_tready,
    input  logic [79:0]   i_s_tdata,
    input  logic          i_s_tuser,
    input  logic          i_m_tvalid,
    input  logic          i_m_tready,
    input  logic [199:0]  i_m_tdata,
    output int            o_errors,
    output int            o_pending,
    output int            o_queries
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [23:0] distance;
        logic [5:0]  seg;
        logic [16:0] t_frac;
        logic [31:0] arc;
        logic [31:0] total;
        logic [23:0] surf;
        logic [15:0] dir_x;
        logic [15:0] dir_z;
        logic [16:0] along;
        logic        inside_flag;
        logic [14:0] speed;
    } t_projection;

    longint      vert_x [64];
    longint      vert_z [64];
    longint      vert_h [64];
    logic [6:0]  line_count;
    logic [1:0]  line_kind;
    logic [23:0] line_half_width;
    t_projection projections [$];

    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned root_round(input longint unsigned n);
        longint unsigned s;
        s = root_floor(n);
        return (n - s * s > s) ? s + 1 : s;
    endfunction

    // Divide by 65536 rounding halves upward.
    function automatic longint round16(input longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic longint unsigned add_sat32(input longint unsigned a,
                                                  input longint unsigned b);
        return (a + b > 64'hFFFFFFFF) ? 64'hFFFFFFFF : a + b;
    endfunction

    function automatic t_projection project_point(input longint px, input longint pz);
        t_projection     p;
        int              n;
        longint unsigned best_e2, best_seg, best_t, best_arc, total, arc;
        longint unsigned len2, len, t, rem, e2, ls, mx, mz, along, speed, dr;
        longint          ax, az, abx, abz, dot, ex, ez, surf, dirx, dirz, desc;
        n = (line_count > 64) ? 64 : int'(line_count);
        best_e2 = 0; best_seg = 0; best_t = 0; best_arc = 0; total = 0; arc = 0;
        surf = 0; dirx = 0; dirz = 0; along = 0; speed = 0;
        if (n == 1) begin
            ex = px - vert_x[0];
            ez = pz - vert_z[0];
            best_e2 = ex * ex + ez * ez;
            surf = vert_h[0];
        end else if (n >= 2) begin
            for (int i = 0; i + 1 < n; i++) begin
                ax = vert_x[i];
                az = vert_z[i];
                abx = vert_x[i + 1] - ax;
                abz = vert_z[i + 1] - az;
                len2 = abx * abx + abz * abz;
                len = root_round(len2);
                dot = (px - ax) * abx + (pz - az) * abz;
                t = 0;
                if (len2 != 0 && dot > 0) begin
                    if (longint'(len2) <= dot) begin
                        t = 65536;
                    end else begin
                        rem = dot;
                        for (int k = 0; k < 16; k++) begin
                            rem = rem << 1;
                            t = t << 1;
                            if (rem >= len2) begin
                                rem = rem - len2;
                                t = t | 1;
                            end
                        end
                    end
                end
                ex = (px - ax) - round16(abx * longint'(t));
                ez = (pz - az) - round16(abz * longint'(t));
                e2 = ex * ex + ez * ez;
                // Strict compare keeps the earliest segment on a tie.
                if (i == 0 || e2 < best_e2) begin
                    best_e2 = e2;
                    best_seg = i;
                    best_t = t;
                    best_arc = add_sat32(arc, (len * t + 32768) >> 16);
                end
                arc = add_sat32(arc, len);
            end
            total = arc;
            surf = vert_h[best_seg] +
                   round16((vert_h[best_seg + 1] - vert_h[best_seg]) * longint'(best_t));
            if (line_kind == pproj_pkg::WK_RIVER) begin
                abx = vert_x[best_seg + 1] - vert_x[best_seg];
                abz = vert_z[best_seg + 1] - vert_z[best_seg];
                len2 = abx * abx + abz * abz;
                if (len2 != 0) begin
                    ls = root_floor(len2 << 12);
                    mx = (abx < 0) ? -abx : abx;
                    mz = (abz < 0) ? -abz : abz;
                    mx = ((mx << 20) + ls / 2) / ls;
                    mz = ((mz << 20) + ls / 2) / ls;
                    if (mx > 16384) mx = 16384;
                    if (mz > 16384) mz = 16384;
                    dirx = (abx < 0) ? -longint'(mx) : longint'(mx);
                    dirz = (abz < 0) ? -longint'(mz) : longint'(mz);
                end
            end
            if (total != 0) begin
                along = (best_arc << 16) / total;
                if (along > 65536) along = 65536;
                if (line_kind == pproj_pkg::WK_RIVER) begin
                    desc = vert_h[0] - vert_h[n - 1];
                    speed = (desc > 0) ? longint'(desc) * 12 * 16384 / total : 0;
                    if (speed < 819) speed = 819;
                    if (speed > 26214) speed = 26214;
                end
            end
        end
        p.distance = 24'hFFFFFF;
        p.inside_flag = 1'b0;
        if (n >= 1) begin
            dr = root_round(best_e2);
            p.inside_flag = (dr <= line_half_width);
            p.distance = (dr > 64'hFFFFFF) ? 24'hFFFFFF : dr[23:0];
        end
        if (line_kind == pproj_pkg::WK_SEA) p.inside_flag = 1'b1;
        p.seg = best_seg[5:0];
        p.t_frac = best_t[16:0];
        p.arc = best_arc[31:0];
        p.total = total[31:0];
        p.surf = surf[23:0];
        p.dir_x = dirx[15:0];
        p.dir_z = dirz[15:0];
        p.along = along[16:0];
        p.speed = speed[14:0];
        return p;
    endfunction

    task automatic report_mismatch(input string field, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t: query %0d field %s got 0x%0h expected 0x%0h",
                 $realtime, o_queries, field, got, want);
        o_errors++;
    endtask

    assign o_pending = projections.size();

    always @(posedge i_clk) begin
        t_projection want;
        t_projection fresh;
        if (!i_rst_n) begin
            line_count = 0;
            line_kind = 0;
            line_half_width = 0;
            o_errors = 0;
            o_queries = 0;
            projections.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pproj_pkg::CFG_VERTEX_COUNT: line_count = i_cfg_data[6:0];
                    pproj_pkg::CFG_WATER_KIND:   line_kind = i_cfg_data[1:0];
                    pproj_pkg::CFG_HALF_WIDTH:   line_half_width = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                if (projections.size() == 0) begin
                    $display("%0t: output beat with no query waiting", $realtime);
                    o_errors++;
                end else begin
                    want = projections.pop_front();
                    if (i_m_tdata[23:0] !== want.distance)
                        report_mismatch("distance", i_m_tdata[23:0], want.distance);
                    if (i_m_tdata[29:24] !== want.seg)
                        report_mismatch("segment", i_m_tdata[29:24], want.seg);
                    if (i_m_tdata[46:30] !== want.t_frac)
                        report_mismatch("t_frac", i_m_tdata[46:30], want.t_frac);
                    if (i_m_tdata[78:47] !== want.arc)
                        report_mismatch("arc_to_foot", i_m_tdata[78:47], want.arc);
                    if (i_m_tdata[110:79] !== want.total)
                        report_mismatch("total_length", i_m_tdata[110:79], want.total);
                    if (i_m_tdata[134:111] !== want.surf)
                        report_mismatch("surface_height", i_m_tdata[134:111], want.surf);
                    if (i_m_tdata[150:135] !== want.dir_x)
                        report_mismatch("flow_dir_x", i_m_tdata[150:135], want.dir_x);
                    if (i_m_tdata[166:151] !== want.dir_z)
                        report_mismatch("flow_dir_z", i_m_tdata[166:151], want.dir_z);
                    if (i_m_tdata[183:167] !== want.along)
                        report_mismatch("along_frac", i_m_tdata[183:167], want.along);
                    if (i_m_tdata[184] !== want.inside_flag)
                        report_mismatch("inside_res", i_m_tdata[184], want.inside_flag);
                    if (i_m_tdata[199:185] !== want.speed)
                        report_mismatch("flow_speed", i_m_tdata[199:185], want.speed);
                    o_queries++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == pproj_pkg::OP_WRITE) begin
                    vert_x[i_s_tdata[5:0]] = longint'(signed'(i_s_tdata[29:6]));
                    vert_z[i_s_tdata[5:0]] = longint'(signed'(i_s_tdata[53:30]));
                    vert_h[i_s_tdata[5:0]] = longint'(signed'(i_s_tdata[77:54]));
                end else begin
                    fresh = project_point(longint'(signed'(i_s_tdata[29:6])),
                                          longint'(signed'(i_s_tdata[53:30])));
                    projections = {projections, fresh};
                end
            end
        end
    end

endmodule

// File: test/polyline_point_projection_top_test.sv
module polyline_point_projection_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 60000;
    localparam int HOLD_CYCLES = 3000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_idx;
    logic [23:0]   i_cfg_data;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [79:0]   s_axis_tdata;
    logic          s_axis_tuser;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [199:0]  m_axis_tdata;

    int  errors, pending, queries_seen;
    int  writes_sent, queries_sent, stall_count;
    bit  quiet, hold_request, sender_gaps;

    polyline_point_projection_top uut (.*);

    polyline_point_projection_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata),
        .o_errors(errors), .o_pending(pending), .o_queries(queries_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("polyline_point_projection_top: mismatch");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    // Output side: random back-pressure, plus one long hold-off on request.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    task automatic send_beat(input logic op, input logic [5:0] slot, input logic [23:0] x,
                             input logic [23:0] z, input logic [23:0] h);
        if (sender_gaps && !quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {2'b00, h, z, x, slot};
        do @(posedge i_clk); while (!s_axis_tready);
        if (op == pproj_pkg::OP_WRITE) writes_sent++;
        else queries_sent++;
    endtask

    task automatic query(input logic [23:0] x, input logic [23:0] z);
        send_beat(pproj_pkg::OP_QUERY, 6'($urandom), x, z, 24'($urandom));
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        // A trailing vertex write may still be in flight.
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_line(input logic [6:0] count, input logic [1:0] kind,
                            input logic [23:0] half_width);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= pproj_pkg::CFG_VERTEX_COUNT;
        i_cfg_data <= {17'd0, count};
        @(posedge i_clk);
        i_cfg_idx <= pproj_pkg::CFG_WATER_KIND;
        i_cfg_data <= {22'd0, kind};
        @(posedge i_clk);
        i_cfg_idx <= pproj_pkg::CFG_HALF_WIDTH;
        i_cfg_data <= half_width;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [23:0] random_coord();
        if ($urandom_range(0, 3) == 0) return 24'($urandom);
        return 24'(int'($urandom_range(0, 40000)) - 20000);
    endfunction

    initial begin
        int            counts [12];
        int            beats;
        logic [6:0]    count;
        logic [23:0]   hw;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = pproj_pkg::OP_WRITE;
        quiet = 1'b0;
        hold_request = 1'b0;
        sender_gaps = 1'b1;
        writes_sent = 0;
        queries_sent = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty line, for sea and for river.
        set_line(7'd0, pproj_pkg::WK_SEA, 24'd0);
        query(24'd0, 24'd0);
        query(24'h800000, 24'h7FFFFF);
        set_line(7'd0, pproj_pkg::WK_RIVER, 24'hFFFFFF);
        query(24'h7FFFFF, 24'h800000);

        // Zero-length first segment, a plain one, then one across the extremes.
        send_beat(pproj_pkg::OP_WRITE, 6'd0, 24'd0, 24'd0, 24'd1000);
        send_beat(pproj_pkg::OP_WRITE, 6'd1, 24'd0, 24'd0, 24'd500);
        send_beat(pproj_pkg::OP_WRITE, 6'd2, 24'd2560, 24'd0, 24'd0);
        send_beat(pproj_pkg::OP_WRITE, 6'd3, 24'h800000, 24'h7FFFFF, 24'h800000);
        set_line(7'd1, pproj_pkg::WK_RIVER, 24'd256);
        query(24'd100, 24'd100);
        set_line(7'd4, pproj_pkg::WK_RIVER, 24'hFFFFFF);
        query(24'd1280, 24'd5);
        query(24'h800000, 24'h800000);
        query(24'h7FFFFF, 24'h7FFFFF);
        query(24'd0, 24'd0);
        set_line(7'd3, pproj_pkg::WK_LAKE, 24'd0);
        query(24'd1280, 24'hFFFF00);
        // Rising line: the head is below the tail.
        send_beat(pproj_pkg::OP_WRITE, 6'd0, 24'd0, 24'd0, 24'hFFFF9C);
        set_line(7'd3, pproj_pkg::WK_RIVER, 24'd0);
        query(24'd3000, 24'd10);
        set_line(7'd2, pproj_pkg::WK_POND, 24'd128);
        query(24'd2000, 24'hFFFF00);

        // Every slot holds a vertex from here on.
        for (int i = 0; i < 64; i++)
            send_beat(pproj_pkg::OP_WRITE, 6'(i), random_coord(), random_coord(),
                      24'($urandom));

        counts = '{2, 5, 64, 8, 3, 0, 1, 16, 4, 6, 2, 7};
        for (int ph = 0; ph < 12; ph++) begin
            count = 7'(counts[ph]);
            case (ph % 4)
                0: hw = 24'd0;
                1: hw = 24'hFFFFFF;
                default: hw = 24'($urandom_range(0, 30000));
            endcase
            set_line(count, 2'($urandom), hw);
            quiet = (ph == 11);
            if (ph == 1) hold_request = 1'b1;
            beats = (count >= 16) ? 30 : 165;
            for (int k = 0; k < beats; k++) begin
                if (ph == 3 && k == beats / 2) drain();
                if ($urandom_range(0, 99) < 45)
                    query(random_coord(), random_coord());
                else
                    send_beat(pproj_pkg::OP_WRITE, 6'($urandom), random_coord(),
                              random_coord(), 24'($urandom));
            end
        end

        drain();
        repeat (400) @(posedge i_clk);
        $display("Covered %0d vertex writes and %0d queries over empty, single-vertex,",
                 writes_sent, queries_sent);
        $display("short and full-length lines of every water kind; %0d results checked.",
                 queries_seen);
        if (errors == 0 && pending == 0)
            $display("polyline_point_projection_top: match");
        else
            $display("polyline_point_projection_top: mismatch");
        $finish;
    end

endmodule

// File: sim.f
rtl/pproj_pkg.sv
rtl/pproj_sqrt.sv
rtl/pproj_div.sv
rtl/polyline_point_projection_top.sv
test/polyline_point_projection_checker.sv
test/polyline_point_projection_top_test.sv
